### sv/hcca_pkg.sv
// ----------------------------------------------------------------------------
// hcca_pkg
// Shared widths, reset values and status codes for the HTTP cache
// current-age pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hcca_pkg;

   localparam int TIME_W  = 64;
   localparam int AGE_W   = 32;
   localparam int STAT_W  = 2;

   localparam int unsigned TICKS_PER_SECOND_DEF = 1000000;

   localparam logic [AGE_W-1:0] CAP_RESET = 32'h8000_0000;

   localparam logic [STAT_W-1:0] STATUS_READY   = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_INVALID = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_ERROR   = 2'd2;

endpackage

`default_nettype wire

### sv/hcca_req_if.sv
// ----------------------------------------------------------------------------
// hcca_req_if
// Request channel: the time facts of one cached response.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcca_req_if
   import hcca_pkg::*;
   ();

   logic                     valid;
   logic                     ready;
   logic                     date_present;
   logic                     date_duplicate;
   logic                     date_invalid;
   logic                     age_invalid;
   logic signed [TIME_W-1:0] date_value;
   logic [AGE_W-1:0]         age_seconds;
   logic signed [TIME_W-1:0] response_wall_time;
   logic [TIME_W-1:0]        request_clock;
   logic [TIME_W-1:0]        response_clock;
   logic [TIME_W-1:0]        now_clock;

   modport source (
      output valid, date_present, date_duplicate, date_invalid, age_invalid,
             date_value, age_seconds, response_wall_time, request_clock,
             response_clock, now_clock,
      input  ready
   );

   modport sink (
      input  valid, date_present, date_duplicate, date_invalid, age_invalid,
             date_value, age_seconds, response_wall_time, request_clock,
             response_clock, now_clock,
      output ready
   );

endinterface

`default_nettype wire

### sv/hcca_rsp_if.sv
// ----------------------------------------------------------------------------
// hcca_rsp_if
// Response channel: status and the age formula terms.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcca_rsp_if
   import hcca_pkg::*;
   ();

   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [TIME_W-1:0] apparent_age;
   logic [TIME_W-1:0] response_delay;
   logic [TIME_W-1:0] corrected_age_value;
   logic [TIME_W-1:0] corrected_initial_age;
   logic [TIME_W-1:0] resident_time;
   logic [TIME_W-1:0] current_age;
   logic [AGE_W-1:0]  current_age_whole_seconds;

   modport source (
      output valid, status, apparent_age, response_delay, corrected_age_value,
             corrected_initial_age, resident_time, current_age,
             current_age_whole_seconds,
      input  ready
   );

   modport sink (
      input  valid, status, apparent_age, response_delay, corrected_age_value,
             corrected_initial_age, resident_time, current_age,
             current_age_whole_seconds,
      output ready
   );

endinterface

`default_nettype wire

### sv/http_cache_current_age.sv
// ----------------------------------------------------------------------------
// http_cache_current_age
// Pipelined current-age calculator for one cached HTTP response: apparent
// age, response delay, corrected ages, resident time, current age and
// current age in whole seconds clamped to a programmable cap.
//
//   channel   dir   handshake         contents
//   req_bus   in    valid/ready       Date/Age flags, Date, Age, wall, clocks
//   rsp_bus   out   valid/ready       status and seven age terms
//   csr       in    csr_we/csr_wdata  age_seconds_cap
//
// One request enters per cycle while the pipeline does not stall; it passes
// through six register stages before its response is offered. Three stages
// form the age terms, then a reciprocal multiply, a back multiply and a
// subtract-and-correct stage give the whole-seconds value. Each stage holds a
// valid bit and fills whenever it is empty or its successor moves, so bubbles
// close up under a stall. Reset clears all valid bits and restores the cap; a
// cap write updates the cap and the clamp threshold at the same edge.
// ----------------------------------------------------------------------------
`default_nettype none

module http_cache_current_age
   import hcca_pkg::*;
   #(
      parameter int unsigned TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
   )
   (
      input  wire logic             clock,
      input  wire logic             reset,
      hcca_req_if.sink              req_bus,
      hcca_rsp_if.source            rsp_bus,
      input  wire logic             csr_we,
      input  wire logic [AGE_W-1:0] csr_wdata
   );

   localparam int TICK_W = $clog2(TICKS_PER_SECOND + 1);
   localparam int SHIFT  = TICK_W - 1;
   localparam int EST_W  = AGE_W + 1;
   localparam int NSTAGE = 6;

   localparam logic [TICK_W-1:0] TICKS_C  = TICK_W'(TICKS_PER_SECOND);
   localparam logic [TIME_W-1:0] TICKS_64 = TIME_W'(TICKS_PER_SECOND);
   localparam logic [TIME_W-1:0] TICKS_X2 = TICKS_64 * TIME_W'(2);
   localparam logic [TIME_W-1:0] TICKS_X3 = TICKS_64 * TIME_W'(3);
   localparam logic [TIME_W-1:0] RECIP_64 =
      (TIME_W'(1) << (AGE_W + SHIFT)) / TICKS_64;
   localparam logic [EST_W-1:0]  RECIP    = RECIP_64[EST_W-1:0];
   localparam logic [TIME_W-1:0] LIMIT_RESET =
      (TIME_W'(CAP_RESET) + TIME_W'(1)) * TICKS_64;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [TIME_W-1:0] apparent;
      logic [TIME_W-1:0] delay;
      logic [TIME_W-1:0] cav;
      logic [TIME_W-1:0] cia;
      logic [TIME_W-1:0] resident;
      logic [TIME_W-1:0] cur;
      logic              over;
      logic [EST_W-1:0]  est;
      logic [TIME_W-1:0] prod;
      logic [AGE_W-1:0]  quo;
   } pipe_type;

   // ---- cap register and clamp threshold (cap + 1) * ticks
   logic [AGE_W-1:0]        cap_ff;
   logic [TIME_W-1:0]       limit_ff;
   logic [AGE_W:0]          cap_inc;
   logic [AGE_W+TICK_W:0]   limit_prod;
   logic [TIME_W-1:0]       limit_in;

   assign cap_inc    = {1'b0, csr_wdata} + (AGE_W+1)'(1);
   assign limit_prod = {TICK_W'(0), cap_inc} * {(AGE_W+1)'(0), TICKS_C};
   assign limit_in   = TIME_W'(limit_prod);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         cap_ff   <= csr_wdata;
         limit_ff <= limit_in;
      end
   end

   // ---- pipeline control
   pipe_type            stage_ff [NSTAGE];
   pipe_type            stage_in [NSTAGE];
   logic [NSTAGE-1:0]   vld_ff;
   logic [NSTAGE-1:0]   vin;
   logic [NSTAGE:0]     rdy;

   assign rdy[NSTAGE] = rsp_bus.ready;
   assign vin[0]      = req_bus.valid;
   assign req_bus.ready = rdy[0];

   // ---- stage 0: clock order, Date selection, differences, Age in ticks
   logic                     clk_err;
   logic signed [TIME_W-1:0] date_sel;
   logic [TIME_W-1:0]        wall_diff;
   logic [AGE_W+TICK_W-1:0]  age_ticks;

   assign clk_err = (req_bus.request_clock > req_bus.response_clock) ||
                    (req_bus.response_clock > req_bus.now_clock);
   assign date_sel = (req_bus.date_present && !req_bus.date_invalid) ?
                     req_bus.date_value : req_bus.response_wall_time;
   assign wall_diff = req_bus.response_wall_time - date_sel;
   assign age_ticks = {TICK_W'(0), req_bus.age_seconds} * {AGE_W'(0), TICKS_C};

   always_comb begin
      stage_in[0] = '0;
      if (clk_err) begin
         stage_in[0].status = STATUS_ERROR;
      end else if (req_bus.date_duplicate) begin
         stage_in[0].status = STATUS_INVALID;
      end else begin
         stage_in[0].status = STATUS_READY;
         if (req_bus.response_wall_time > date_sel) begin
            stage_in[0].apparent = wall_diff;
         end
         stage_in[0].delay    = req_bus.response_clock - req_bus.request_clock;
         stage_in[0].resident = req_bus.now_clock - req_bus.response_clock;
         // hold Age in ticks in the cav slot until the next stage
         if (!req_bus.age_invalid) begin
            stage_in[0].cav = TIME_W'(age_ticks);
         end
      end
   end

   // ---- stage 1: corrected age value and corrected initial age
   logic [TIME_W:0]   cav_sum;
   logic [TIME_W-1:0] cav_sat;

   assign cav_sum = {1'b0, stage_ff[0].cav} + {1'b0, stage_ff[0].delay};
   assign cav_sat = cav_sum[TIME_W] ? '1 : cav_sum[TIME_W-1:0];

   always_comb begin
      stage_in[1]     = stage_ff[0];
      stage_in[1].cav = cav_sat;
      stage_in[1].cia = (stage_ff[0].apparent > cav_sat) ? stage_ff[0].apparent
                                                         : cav_sat;
   end

   // ---- stage 2: current age and clamp decision
   logic [TIME_W:0]   cur_sum;
   logic [TIME_W-1:0] cur_sat;

   assign cur_sum = {1'b0, stage_ff[1].cia} + {1'b0, stage_ff[1].resident};
   assign cur_sat = cur_sum[TIME_W] ? '1 : cur_sum[TIME_W-1:0];

   always_comb begin
      stage_in[2]      = stage_ff[1];
      stage_in[2].cur  = cur_sat;
      stage_in[2].over = (cur_sat >= limit_ff);
   end

   // ---- stage 3: quotient estimate by reciprocal, low by at most three
   logic [EST_W-1:0]   scaled;
   logic [2*EST_W-1:0] est_prod;

   assign scaled   = EST_W'(stage_ff[2].cur >> SHIFT);
   assign est_prod = {EST_W'(0), scaled} * {EST_W'(0), RECIP};

   always_comb begin
      stage_in[3]     = stage_ff[2];
      stage_in[3].est = est_prod[AGE_W +: EST_W];
   end

   // ---- stage 4: estimate times ticks
   logic [EST_W+TICK_W-1:0] back_prod;

   assign back_prod = {TICK_W'(0), stage_ff[3].est} * {EST_W'(0), TICKS_C};

   always_comb begin
      stage_in[4]      = stage_ff[3];
      stage_in[4].prod = TIME_W'(back_prod);
   end

   // ---- stage 5: remainder and final correction
   logic [TIME_W-1:0] rem;
   logic [1:0]        fix;

   assign rem = stage_ff[4].cur - stage_ff[4].prod;
   assign fix = (rem >= TICKS_X3) ? 2'd3 :
                (rem >= TICKS_X2) ? 2'd2 :
                (rem >= TICKS_64) ? 2'd1 : 2'd0;

   always_comb begin
      stage_in[5]     = stage_ff[4];
      stage_in[5].quo = stage_ff[4].est[AGE_W-1:0] + AGE_W'(fix);
   end

   // ---- stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NSTAGE; i++) begin
            if (rdy[i]) begin
               vld_ff[i] <= vin[i];
            end
         end
      end
   end

   for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
      if (k > 0) begin : g_vin
         assign vin[k] = vld_ff[k-1];
      end

      assign rdy[k] = !vld_ff[k] || rdy[k+1];

      always_ff @(posedge clock) begin
         if (rdy[k] && vin[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   // ---- response
   assign rsp_bus.valid                 = vld_ff[NSTAGE-1];
   assign rsp_bus.status                = stage_ff[NSTAGE-1].status;
   assign rsp_bus.apparent_age          = stage_ff[NSTAGE-1].apparent;
   assign rsp_bus.response_delay        = stage_ff[NSTAGE-1].delay;
   assign rsp_bus.corrected_age_value   = stage_ff[NSTAGE-1].cav;
   assign rsp_bus.corrected_initial_age = stage_ff[NSTAGE-1].cia;
   assign rsp_bus.resident_time         = stage_ff[NSTAGE-1].resident;
   assign rsp_bus.current_age           = stage_ff[NSTAGE-1].cur;
   assign rsp_bus.current_age_whole_seconds =
      stage_ff[NSTAGE-1].over ? cap_ff : stage_ff[NSTAGE-1].quo;

endmodule

`default_nettype wire

### sv/hcca_chk.sv
// ----------------------------------------------------------------------------
// hcca_chk
// Port-level checks for the current-age pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hcca_chk
   import hcca_pkg::*;
   (
      input wire logic              clock,
      input wire logic              reset,
      input wire logic              rsp_valid,
      input wire logic              rsp_ready,
      input wire logic [STAT_W-1:0] rsp_status,
      input wire logic [TIME_W-1:0] rsp_apparent_age,
      input wire logic [TIME_W-1:0] rsp_corrected_age_value,
      input wire logic [TIME_W-1:0] rsp_corrected_initial_age,
      input wire logic [TIME_W-1:0] rsp_current_age,
      input wire logic [AGE_W-1:0]  rsp_current_age_whole_seconds
   );

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_current_age))
      else $error("response payload changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_READY |->
         rsp_apparent_age == '0 && rsp_corrected_initial_age == '0 &&
         rsp_current_age == '0 && rsp_current_age_whole_seconds == '0)
      else $error("failed request carries nonzero age terms");

   a_age_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_corrected_initial_age >= rsp_apparent_age &&
         rsp_corrected_initial_age >= rsp_corrected_age_value &&
         rsp_current_age >= rsp_corrected_initial_age)
      else $error("age terms out of order");

endmodule

bind http_cache_current_age hcca_chk u_hcca_chk (
   .clock                         (clock),
   .reset                         (reset),
   .rsp_valid                     (rsp_bus.valid),
   .rsp_ready                     (rsp_bus.ready),
   .rsp_status                    (rsp_bus.status),
   .rsp_apparent_age              (rsp_bus.apparent_age),
   .rsp_corrected_age_value       (rsp_bus.corrected_age_value),
   .rsp_corrected_initial_age     (rsp_bus.corrected_initial_age),
   .rsp_current_age               (rsp_bus.current_age),
   .rsp_current_age_whole_seconds (rsp_bus.current_age_whole_seconds)
);

`default_nettype wire
